// ----- src/register_bank_with_auto_increment_core_defines.svh -----
// Assertion macros used by the checker file.
// No dependencies; pulled in by `include where assertions are written.
`ifndef REGISTER_BANK_WITH_AUTO_INCREMENT_CORE_DEFINES_SVH
`define REGISTER_BANK_WITH_AUTO_INCREMENT_CORE_DEFINES_SVH

// Clocked on clock, muted while reset is high.
`define RBAI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked on clock, also checked across reset.
`define RBAI_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- src/rbai_pkg.sv -----
// Shared types, codes and helpers for the register bank core.
// No dependencies; imported by every module of the block.
package rbai_pkg;

   localparam int NUM_REGS_DEFAULT = 41;
   localparam int MASK_BITS        = 41;
   localparam int MASK_IDX_W       = $clog2(MASK_BITS);
   localparam int IDX_W            = 6;
   localparam int SCAN_W           = IDX_W + 1;
   localparam int BYTE_W           = 8;
   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;

   localparam int CSR_DATA_W   = 64;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_WORD_LSB = 3;
   localparam int CSR_WORD_W   = CSR_ADDR_W - CSR_WORD_LSB;

   localparam logic [CSR_WORD_W-1:0] CSR_IDX_MASK = CSR_WORD_W'(0);
   localparam logic [MASK_BITS-1:0]  MASK_RESET   = MASK_BITS'(8);

   localparam logic [CMD_W-1:0] CMD_ADDR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data_byte;
   } rbai_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    reg_index;
   } rbai_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } rbai_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_busy;
   } rbai_stat_type;

   // Registers past the mask width have no bit and are writable.
   function automatic logic is_read_only(input logic [MASK_BITS-1:0] mask,
                                         input logic [SCAN_W-1:0] idx);
      logic in_mask;
      in_mask = (idx < SCAN_W'(MASK_BITS));
      return in_mask && mask[idx[MASK_IDX_W-1:0]];
   endfunction

endpackage

// ----- src/rbai_csr.sv -----
// APB-style configuration register: the read-only mask.
// Depends on rbai_pkg.
module rbai_csr
   import rbai_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [MASK_BITS-1:0]  ro_mask
);

   logic [MASK_BITS-1:0]  mask_ff, mask_in;
   logic [CSR_WORD_W-1:0] word;
   logic                  hit;

   assign word = csr_paddr[CSR_ADDR_W-1:CSR_WORD_LSB];
   assign hit  = (word == CSR_IDX_MASK);

   always_comb begin
      mask_in = mask_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         mask_in = csr_pwdata[MASK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign csr_prdata = hit ? CSR_DATA_W'(mask_ff) : '0;
   assign csr_pready = 1'b1;
   assign ro_mask    = mask_ff;

endmodule

// ----- src/rbai_ctrl.sv -----
// Controller: sequences one item at a time and owns the result valid.
// Depends on rbai_pkg.
module rbai_ctrl
   import rbai_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rbai_ctrl_type ctrl,
   input  rbai_stat_type stat
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctrl.load   = (state_ff == ST_IDLE) && req_valid;
      ctrl.step   = (state_ff == ST_EXEC) && stat.scan_busy;
      ctrl.finish = (state_ff == ST_EXEC) && !stat.scan_busy && out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ctrl.finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = ctrl.finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/rbai_dpath.sv -----
// Datapath: register bank memory, pointers, write scan and result register.
// Depends on rbai_pkg; driven by rbai_ctrl.
module rbai_dpath
   import rbai_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rbai_ctrl_type        ctrl,
   output rbai_stat_type        stat,
   input  rbai_req_type         req_data,
   input  logic [MASK_BITS-1:0] ro_mask,
   output rbai_rsp_type         rsp_data
);

   localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [SCAN_W-1:0] NREGS_S = SCAN_W'(NUM_REGS);
   localparam logic [BYTE_W-1:0] NREGS_B = BYTE_W'(NUM_REGS);

   logic [BYTE_W-1:0]   bank_mem [NUM_REGS];
   logic [NUM_REGS-1:0] bank_vld_ff, bank_vld_in;

   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              wr_open_ff, wr_open_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   rbai_req_type      item_ff, item_in;
   rbai_rsp_type      rsp_ff, rsp_in;
   logic [BYTE_W-1:0] rdata_ff;
   logic              rvld_ff;

   logic [IDX_W-1:0]  rd_idx;
   logic [SCAN_W-1:0] rd_next, scan_next;
   logic              scan_in_range;
   logic              wr_en;

   // out-of-range read pointer reads register 0
   assign rd_idx        = ({1'b0, rd_ptr_ff} >= NREGS_S) ? '0 : rd_ptr_ff;
   assign rd_next       = {1'b0, rd_idx} + SCAN_W'(1);
   assign scan_next     = scan_ff + SCAN_W'(1);
   assign scan_in_range = (scan_ff < NREGS_S);

   assign stat.scan_busy = (item_ff.cmd == CMD_DATA) && wr_open_ff && scan_in_range
                           && is_read_only(ro_mask, scan_ff);

   assign wr_en = ctrl.finish && (item_ff.cmd == CMD_DATA) && wr_open_ff && scan_in_range;

   always_comb begin
      item_in     = item_ff;
      scan_in     = scan_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      wr_open_in  = wr_open_ff;
      bank_vld_in = bank_vld_ff;
      rsp_in      = rsp_ff;

      if (ctrl.load) begin
         item_in = req_data;
         scan_in = {1'b0, wr_ptr_ff};
      end

      if (ctrl.step) begin
         scan_in = scan_next;
      end

      if (ctrl.finish) begin
         rsp_in = '0;
         unique case (item_ff.cmd)
            CMD_ADDR: begin
               if (item_ff.data_byte >= NREGS_B) begin
                  rsp_in.status = STATUS_RANGE;
                  wr_open_in    = 1'b0;
               end else begin
                  rd_ptr_in        = item_ff.data_byte[IDX_W-1:0];
                  wr_ptr_in        = item_ff.data_byte[IDX_W-1:0];
                  wr_open_in       = !is_read_only(ro_mask,
                                        {1'b0, item_ff.data_byte[IDX_W-1:0]});
                  rsp_in.reg_index = item_ff.data_byte[IDX_W-1:0];
               end
            end
            CMD_DATA: begin
               if (!wr_open_ff) begin
                  rsp_in.status = STATUS_IGNORED;
               end else if (!scan_in_range) begin
                  rsp_in.status = STATUS_IGNORED;
                  wr_open_in    = 1'b0;
               end else begin
                  rsp_in.reg_index                   = scan_ff[IDX_W-1:0];
                  bank_vld_in[scan_ff[ADDR_W-1:0]] = 1'b1;
                  if (scan_next >= NREGS_S) begin
                     wr_open_in = 1'b0;
                     wr_ptr_in  = '0;
                  end else begin
                     wr_ptr_in = scan_next[IDX_W-1:0];
                  end
               end
            end
            CMD_READ: begin
               rsp_in.read_data = rvld_ff ? rdata_ff : '0;
               rsp_in.reg_index = rd_idx;
               rd_ptr_in        = (rd_next >= NREGS_S) ? '0 : rd_next[IDX_W-1:0];
            end
            default: begin
               rsp_in.status = STATUS_IGNORED;
            end
         endcase
      end
   end

   // bank: one write port, one registered read port at the read pointer
   always_ff @(posedge clock) begin
      rdata_ff <= bank_mem[rd_idx[ADDR_W-1:0]];
      if (wr_en) begin
         bank_mem[scan_ff[ADDR_W-1:0]] <= item_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_vld_ff <= '0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         wr_open_ff  <= 1'b0;
      end else begin
         bank_vld_ff <= bank_vld_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         wr_open_ff  <= wr_open_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
      rvld_ff <= bank_vld_ff[rd_idx[ADDR_W-1:0]];
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/register_bank_with_auto_increment_core.sv -----
// Top level of the auto-increment register bank core.
// Depends on rbai_pkg, rbai_csr, rbai_ctrl and rbai_dpath.
//
// Channel  Ports                              Transfer when
// -------  ---------------------------------  -----------------------------------
// request  req_valid, req_stall, req_data     req_valid && !req_stall
// result   rsp_valid, rsp_stall, rsp_data     rsp_valid && !rsp_stall
// config   csr_psel/penable/pwrite/paddr/...  psel && penable && pwrite && pready
//
// An item is accepted in idle and then executes; the result register loads when
// execute finishes. A data write first skips the read-only registers in its way;
// the skip walks the mask one register per cycle.
// Reset (synchronous) clears pointers, open-write flag, per-register valid bits
// (unwritten registers read zero) and sets the mask to 8; no clearing pass.
// A stalled result holds; the next request is still taken, and waits in execute.
module register_bank_with_auto_increment_core
   import rbai_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rbai_req_type          req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rbai_rsp_type          rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   rbai_ctrl_type        ctrl;
   rbai_stat_type        stat;
   logic [MASK_BITS-1:0] ro_mask;

   // mask register; the user must write it only while no item is in flight (not enforced here)
   rbai_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ro_mask     (ro_mask)
   );

   // load on accept, step while skipping read-only registers, finish when the
   // skip is done and the result register is free
   rbai_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   // bank, pointers and result register; bank and pointers commit on finish
   rbai_dpath #(
      .NUM_REGS (NUM_REGS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .stat     (stat),
      .req_data (req_data),
      .ro_mask  (ro_mask),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/rbai_checker.sv -----
// Port-level checks for the register bank core, bound to the top level.
// Depends on rbai_pkg and the shared assertion macro header.
`include "register_bank_with_auto_increment_core_defines.svh"

module rbai_checker
   import rbai_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rbai_rsp_type          rsp_data
);

   // a stalled result stays up and unchanged
   `RBAI_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one item in flight: an accepted request blocks the next cycle
   `RBAI_ASSERT(a_one_item, req_valid && !req_stall |=> req_stall, "request taken while busy")

   // failed items name no register and return no data
   `RBAI_ASSERT(a_fail_zero, rsp_valid && (rsp_data.status != STATUS_DONE) |-> rsp_data.read_data == '0 && rsp_data.reg_index == '0, "failed item carries data")

   // reset leaves both channels idle
   `RBAI_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind register_bank_with_auto_increment_core rbai_checker u_rbai_checker (.*);

// ----- verif/tb_register_bank_with_auto_increment_core.sv -----
// Self-checking testbench for the auto-increment register bank core.
// Depends on rbai_pkg and register_bank_with_auto_increment_core; a built-in
// predictor models the bank, both pointers and the read-only mask.
module tb_register_bank_with_auto_increment_core
   import rbai_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANK_DEPTH = NUM_REGS_DEFAULT;
   // Command code the block does not define; must be ignored.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // The mask is register 0; 64-bit CSR words put it at byte address 0.
   localparam logic [CSR_ADDR_W-1:0] ADDR_RO_MASK = CSR_ADDR_W'(0);
   // Receiver hold-offs long enough to back the block up into the request side.
   localparam int HOLD_CYCLES = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   rbai_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rbai_rsp_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   register_bank_with_auto_increment_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predicted state of the bank
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0]    bank_model [BANK_DEPTH];
   int                   rd_ptr;
   int                   wr_ptr;
   bit                   wr_open;
   logic [MASK_BITS-1:0] ro_mask;

   rbai_req_type req_backlog [$];     // items waiting to be offered
   rbai_rsp_type predicted_rsps [$];  // results owed by the block, oldest first
   int           error_count = 0;
   int           rsp_seen = 0;

   function automatic bit reg_locked(input int idx);
      return (idx < MASK_BITS) && ro_mask[idx];
   endfunction

   // Applies one accepted request to the predicted state and returns the
   // result the block must produce for it.
   function automatic rbai_rsp_type apply_access(input rbai_req_type item);
      rbai_rsp_type res;
      int           p;
      res = '0;
      res.status = STATUS_DONE;
      case (item.cmd)
         CMD_ADDR: begin
            if (item.data_byte >= BANK_DEPTH) begin
               // Bad address: pointers keep their values, any open write closes.
               res.status = STATUS_RANGE;
               wr_open = 1'b0;
            end else begin
               rd_ptr = item.data_byte;
               wr_ptr = item.data_byte;
               // Addressing a read-only register opens nothing.
               wr_open = !reg_locked(item.data_byte);
               res.reg_index = IDX_W'(item.data_byte);
            end
         end
         CMD_DATA: begin
            if (!wr_open) begin
               res.status = STATUS_IGNORED;
            end else begin
               // Skip read-only registers, but never past the end of the bank.
               p = wr_ptr;
               while (p < BANK_DEPTH && reg_locked(p))
                  p++;
               if (p >= BANK_DEPTH) begin
                  res.status = STATUS_IGNORED;
                  wr_open = 1'b0;
               end else begin
                  bank_model[p] = item.data_byte;
                  res.reg_index = IDX_W'(p);
                  p++;
                  if (p >= BANK_DEPTH) begin
                     // Last register written: the write is over.
                     wr_open = 1'b0;
                     p = 0;
                  end
                  wr_ptr = p;
               end
            end
         end
         CMD_READ: begin
            p = (rd_ptr >= BANK_DEPTH) ? 0 : rd_ptr;
            res.read_data = bank_model[p];
            res.reg_index = IDX_W'(p);
            // Reads wrap at the bank size.
            rd_ptr = (p + 1 >= BANK_DEPTH) ? 0 : p + 1;
         end
         default: res.status = STATUS_IGNORED;
      endcase
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long; none in calm spells.
   function automatic int draw_idle(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offers backlog items with random gaps between transfers.
   // A stalled item stays on the bus unchanged.
   // ---------------------------------------------------------------------
   int gap_left = 0;
   int send_cycles = 0;
   bit send_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         send_cycles++;
         if (send_cycles % 100 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
         if (req_valid && !req_stall) begin
            // Transfer taken: predict it now, while the state is in step.
            predicted_rsps.push_back(apply_access(req_data));
            gap_left = draw_idle(send_calm);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && req_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks each transfer against the oldest prediction and
   // drives a random stall. Twice in the run it holds off for a long stretch
   // so the block fills up and pushes back on the request side.
   // ---------------------------------------------------------------------
   int           stall_left = 0;
   int           hold_left = 0;
   int           recv_cycles = 0;
   bit           recv_calm = 1'b0;
   rbai_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         recv_cycles++;
         if (recv_cycles % 100 == 50)
            recv_calm = ($urandom_range(0, 3) == 0);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (predicted_rsps.size() == 0) begin
               $error("result transfer with nothing expected: %p", rsp_data);
               error_count++;
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data: expected %0d, got %0d",
                         want.read_data, rsp_data.read_data);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.reg_index !== want.reg_index) begin
                  $error("reg_index: expected %0d, got %0d",
                         want.reg_index, rsp_data.reg_index);
                  error_count++;
               end
            end
            if (rsp_seen == 400 || rsp_seen == 1400)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = draw_idle(recv_calm);
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
      rbai_req_type item;
      item.cmd       = cmd;
      item.data_byte = value;
      req_backlog.push_back(item);
   endtask

   // Block is idle once nothing is queued, offered or owed.
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || predicted_rsps.size() != 0)
         @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle; mask updates on the transfer.
   task automatic write_ro_mask(input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= ADDR_RO_MASK;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      ro_mask = value[MASK_BITS-1:0];
      @(negedge clock);
   endtask

   // Mostly well-formed write and read bursts with random content, plus
   // bare reads, broken sequences and random noise.
   task automatic add_random_items(input int count);
      int made;
      int n;
      int r;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            if ($urandom_range(0, 9) == 0)
               add_item(CMD_ADDR, BYTE_W'($urandom_range(BANK_DEPTH, 255)));
            else
               add_item(CMD_ADDR, BYTE_W'($urandom_range(0, BANK_DEPTH - 1)));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, BANK_DEPTH + 4)
                                            : $urandom_range(1, 6);
            repeat (n) add_item(CMD_DATA, BYTE_W'($urandom));
            made += n + 1;
         end else if (r < 80) begin
            add_item(CMD_ADDR, BYTE_W'($urandom_range(0, BANK_DEPTH - 1)));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, BANK_DEPTH + 4)
                                            : $urandom_range(1, 6);
            repeat (n) add_item(CMD_READ, BYTE_W'($urandom));
            made += n + 1;
         end else if (r < 90) begin
            n = $urandom_range(1, 4);
            repeat (n) add_item(CMD_READ, BYTE_W'($urandom));
            made += n;
         end else begin
            add_item(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom));
            made++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (bank_model[i])
         bank_model[i] = '0;
      rd_ptr  = 0;
      wr_ptr  = 0;
      wr_open = 1'b0;
      ro_mask = MASK_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset mask (register 3 read-only).
      add_item(CMD_READ, 8'hFF);     // unwritten register reads zero
      add_item(CMD_DATA, 8'h5A);     // data with no write open
      add_item(CMD_ADDR, 8'd41);     // first address out of range
      add_item(CMD_ADDR, 8'hFF);
      add_item(CMD_ADDR, 8'd3);      // read-only target: data that follows is ignored
      add_item(CMD_DATA, 8'h11);
      add_item(CMD_ADDR, 8'd2);      // burst that skips over register 3
      add_item(CMD_DATA, 8'hFF);
      add_item(CMD_DATA, 8'h00);
      add_item(CMD_DATA, 8'hA5);
      add_item(CMD_ADDR, 8'd39);     // write up to the end of the bank
      add_item(CMD_DATA, 8'h81);
      add_item(CMD_DATA, 8'h7E);
      add_item(CMD_DATA, 8'h42);     // after the last register: ignored
      add_item(CMD_UNUSED, 8'hFF);
      add_item(CMD_ADDR, 8'd40);     // reads wrap from the last register to 0
      repeat (3) add_item(CMD_READ, 8'h00);
      add_item(CMD_ADDR, 8'd2);
      repeat (3) add_item(CMD_READ, 8'h00);
      wait_idle();

      // Top registers read-only: a write runs out of targets before the end.
      write_ro_mask(CSR_DATA_W'(41'h1C0_0000_0000));
      add_item(CMD_ADDR, 8'd36);
      repeat (4) add_item(CMD_DATA, BYTE_W'($urandom));
      add_item(CMD_DATA, 8'h33);
      wait_idle();

      // Random phases across a range of masks, extremes included.
      write_ro_mask('0);
      add_random_items(400);
      wait_idle();
      write_ro_mask('1);
      add_random_items(100);
      wait_idle();
      write_ro_mask({$urandom, $urandom} & {$urandom, $urandom});
      add_random_items(450);
      wait_idle();
      write_ro_mask({$urandom, $urandom} | {$urandom, $urandom});
      add_random_items(350);
      wait_idle();
      write_ro_mask(CSR_DATA_W'(41'h100_0000_0001));
      add_random_items(300);
      wait_idle();
      write_ro_mask(CSR_DATA_W'(MASK_RESET));
      add_random_items(400);
      wait_idle();

      // Drain: allow for the longest skip walk before the final verdict.
      repeat (BANK_DEPTH + 20) @(posedge clock);
      if (predicted_rsps.size() != 0) begin
         $error("%0d results never arrived", predicted_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
